@@ hdl/tbb_pkg.sv @@
package tbb_pkg;

  typedef enum logic {
    ReqLoad    = 1'b0,
    ReqCompute = 1'b1
  } req_type_e;

  localparam int NCoeffs  = 12;
  localparam int IdxW     = 4;
  localparam int ValW     = 32;
  localparam int FracW    = 16;
  localparam int ProdW    = 2 * ValW - FracW;
  localparam int SumW     = ProdW + 2;
  localparam int HalfW    = 31;
  localparam int InDataW  = 232;
  localparam int OutDataW = 192;

  localparam logic signed [ValW-1:0] QOne = 32'sh0001_0000;

  typedef logic signed [ValW-1:0] q_t;

endpackage

@@ hdl/transformed_box_bounds.sv @@
// Channel   Dir  tdata / tuser (fields from bit 0 up)
// s_axis    in   tdata: entry_index[3:0], entry_value[35:4], origin_x[67:36],
//                origin_y[99:68], origin_z[131:100], size_x[163:132],
//                size_y[195:164], size_z[227:196], zero fill to 232 bits
//                tuser: req_type (0 loads a coefficient, 1 computes a box)
// m_axis    out  tdata: center_x[31:0], center_y[63:32], center_z[95:64],
//                half_x[126:96], half_y[157:127], half_z[188:158], zero fill
//
// One word is accepted per cycle while s_axis_tready is high.
// A compute word returns its result after four register stages: input, products, axis bounds, result.
// A load word writes its coefficient when it leaves the input stage and gives no result.
// Each stage moves when it is empty or the stage after it moves, so a stalled output
// stops the pipe only once all four stages are full.
// Reset clears all stage valid bits and loads the identity matrix.
module transformed_box_bounds #(
  parameter int COORD_WIDTH = 32
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         s_axis_tvalid,
  output logic                         s_axis_tready,
  // entry_index, entry_value, origin_x/y/z, size_x/y/z, zero fill
  input  logic [tbb_pkg::InDataW-1:0]  s_axis_tdata,
  // req_type
  input  logic                         s_axis_tuser,
  output logic                         m_axis_tvalid,
  input  logic                         m_axis_tready,
  // center_x/y/z, half_x/y/z, zero fill
  output logic [tbb_pkg::OutDataW-1:0] m_axis_tdata
);
  import tbb_pkg::*;

  localparam int WW = ((COORD_WIDTH > ValW) ? COORD_WIDTH : ValW) + 2;
  localparam logic signed [WW-1:0] CMax = {{(WW-HalfW){1'b0}}, {HalfW{1'b1}}};
  localparam logic signed [WW-1:0] CMin = {{(WW-HalfW){1'b1}}, {HalfW{1'b0}}};

  logic en_a, en_b, en_c, en_d;
  logic va_q, vb_q, vc_q, vd_q;

  req_type_e       a_type_q;
  logic [IdxW-1:0] a_idx_q;
  q_t              a_val_q;
  q_t              a_org_q [3];
  q_t              a_far_q [3];
  q_t              far_d [3];

  q_t coef_q [NCoeffs];

  logic signed [2*ValW-1:0] full_p [3][3][2];
  logic signed [ProdW-1:0]  prod_q [3][3][2];
  q_t                       trans_q [3];

  logic signed [SumW-1:0]        lo_sum [3];
  logic signed [SumW-1:0]        hi_sum [3];
  logic signed [COORD_WIDTH-1:0] mn_d [3];
  logic signed [COORD_WIDTH-1:0] mx_d [3];
  logic signed [COORD_WIDTH-1:0] mn_q [3];
  logic signed [COORD_WIDTH-1:0] mx_q [3];

  logic [ValW-1:0]  ctr_d [3];
  logic [HalfW-1:0] half_d [3];
  logic [ValW-1:0]  ctr_q [3];
  logic [HalfW-1:0] half_q [3];

  assign en_d          = !vd_q || m_axis_tready;
  assign en_c          = !vc_q || en_d;
  assign en_b          = !vb_q || en_c;
  assign en_a          = !va_q || en_b;
  assign s_axis_tready = en_a;
  assign m_axis_tvalid = vd_q;

  always_comb begin
    logic signed [ValW:0] s;
    s = '0;
    for (int a = 0; a < 3; a++) begin
      s = (ValW+1)'($signed(s_axis_tdata[36+32*a +: 32]))
        + (ValW+1)'($signed(s_axis_tdata[132+32*a +: 32]));
      if (s[ValW] != s[ValW-1]) begin
        far_d[a] = s[ValW] ? {1'b1, {(ValW-1){1'b0}}} : {1'b0, {(ValW-1){1'b1}}};
      end else begin
        far_d[a] = s[ValW-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q <= 1'b0;
    end else if (en_a) begin
      va_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_a && s_axis_tvalid) begin
      a_type_q <= req_type_e'(s_axis_tuser);
      a_idx_q  <= s_axis_tdata[3:0];
      a_val_q  <= s_axis_tdata[35:4];
      for (int a = 0; a < 3; a++) begin
        a_org_q[a] <= s_axis_tdata[36+32*a +: 32];
        a_far_q[a] <= far_d[a];
      end
    end
  end

  // Loads write the matrix as they leave the input stage, so every compute word
  // ahead of them has already taken its products and translation.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NCoeffs; i++) begin
        coef_q[i] <= (i / 4 == i % 4) ? QOne : '0;
      end
    end else if (va_q && en_b && a_type_q == ReqLoad && a_idx_q < IdxW'(NCoeffs)) begin
      coef_q[a_idx_q] <= a_val_q;
    end
  end

  always_comb begin
    for (int r = 0; r < 3; r++) begin
      for (int a = 0; a < 3; a++) begin
        full_p[r][a][0] = (2*ValW)'(coef_q[r*4+a]) * (2*ValW)'(a_org_q[a]);
        full_p[r][a][1] = (2*ValW)'(coef_q[r*4+a]) * (2*ValW)'(a_far_q[a]);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vb_q <= 1'b0;
    end else if (en_b) begin
      vb_q <= va_q && a_type_q == ReqCompute;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_b && va_q && a_type_q == ReqCompute) begin
      for (int r = 0; r < 3; r++) begin
        trans_q[r] <= coef_q[r*4+3];
        for (int a = 0; a < 3; a++) begin
          prod_q[r][a][0] <= full_p[r][a][0][2*ValW-1:FracW];
          prod_q[r][a][1] <= full_p[r][a][1][2*ValW-1:FracW];
        end
      end
    end
  end

  // Each product is monotone in its coordinate, so the corner extremes split
  // into independent per-term choices.
  always_comb begin
    for (int r = 0; r < 3; r++) begin
      lo_sum[r] = SumW'(trans_q[r]);
      hi_sum[r] = SumW'(trans_q[r]);
      for (int a = 0; a < 3; a++) begin
        if (prod_q[r][a][0] < prod_q[r][a][1]) begin
          lo_sum[r] = lo_sum[r] + SumW'(prod_q[r][a][0]);
          hi_sum[r] = hi_sum[r] + SumW'(prod_q[r][a][1]);
        end else begin
          lo_sum[r] = lo_sum[r] + SumW'(prod_q[r][a][1]);
          hi_sum[r] = hi_sum[r] + SumW'(prod_q[r][a][0]);
        end
      end
    end
  end

  if (COORD_WIDTH >= SumW) begin : g_wide
    always_comb begin
      for (int r = 0; r < 3; r++) begin
        mn_d[r] = COORD_WIDTH'(lo_sum[r]);
        mx_d[r] = COORD_WIDTH'(hi_sum[r]);
      end
    end
  end else begin : g_sat
    localparam logic signed [SumW-1:0] SatHi =
      {{(SumW-COORD_WIDTH+1){1'b0}}, {(COORD_WIDTH-1){1'b1}}};
    localparam logic signed [SumW-1:0] SatLo =
      {{(SumW-COORD_WIDTH+1){1'b1}}, {(COORD_WIDTH-1){1'b0}}};
    always_comb begin
      for (int r = 0; r < 3; r++) begin
        if (lo_sum[r] > SatHi) begin
          mn_d[r] = SatHi[COORD_WIDTH-1:0];
        end else if (lo_sum[r] < SatLo) begin
          mn_d[r] = SatLo[COORD_WIDTH-1:0];
        end else begin
          mn_d[r] = lo_sum[r][COORD_WIDTH-1:0];
        end
        if (hi_sum[r] > SatHi) begin
          mx_d[r] = SatHi[COORD_WIDTH-1:0];
        end else if (hi_sum[r] < SatLo) begin
          mx_d[r] = SatLo[COORD_WIDTH-1:0];
        end else begin
          mx_d[r] = hi_sum[r][COORD_WIDTH-1:0];
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vc_q <= 1'b0;
    end else if (en_c) begin
      vc_q <= vb_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_c && vb_q) begin
      for (int r = 0; r < 3; r++) begin
        mn_q[r] <= mn_d[r];
        mx_q[r] <= mx_d[r];
      end
    end
  end

  always_comb begin
    logic signed [WW-1:0] sum;
    logic signed [WW-1:0] dif;
    sum = '0;
    dif = '0;
    for (int r = 0; r < 3; r++) begin
      sum = (WW'(mx_q[r]) + WW'(mn_q[r])) >>> 1;
      dif = (WW'(mx_q[r]) - WW'(mn_q[r])) >>> 1;
      if (sum > CMax) begin
        ctr_d[r] = CMax[ValW-1:0];
      end else if (sum < CMin) begin
        ctr_d[r] = CMin[ValW-1:0];
      end else begin
        ctr_d[r] = sum[ValW-1:0];
      end
      if (dif > CMax) begin
        half_d[r] = CMax[HalfW-1:0];
      end else begin
        half_d[r] = dif[HalfW-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vd_q <= 1'b0;
    end else if (en_d) begin
      vd_q <= vc_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_d && vc_q) begin
      for (int r = 0; r < 3; r++) begin
        ctr_q[r]  <= ctr_d[r];
        half_q[r] <= half_d[r];
      end
    end
  end

  assign m_axis_tdata = {3'b000, half_q[2], half_q[1], half_q[0],
                         ctr_q[2], ctr_q[1], ctr_q[0]};

`ifndef SYNTHESIS
  a_load_writes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (va_q && en_b && a_type_q == ReqLoad && a_idx_q < IdxW'(NCoeffs))
    |=> coef_q[$past(a_idx_q)] == $past(a_val_q))
    else $error("coefficient load did not take effect");

  a_ready_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> (va_q && vb_q && vc_q && vd_q && !m_axis_tready))
    else $error("input stalled while the pipeline has room");

  a_bounds_x: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vc_q |-> mx_q[0] >= mn_q[0])
    else $error("x bounds inverted");

  a_bounds_y: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vc_q |-> mx_q[1] >= mn_q[1])
    else $error("y bounds inverted");

  a_bounds_z: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vc_q |-> mx_q[2] >= mn_q[2])
    else $error("z bounds inverted");
`endif

endmodule
